/* rtl/core/frame_header_deframer_core_assert.svh */
// Assertion macros shared by the deframer checker.
`ifndef FRAME_HEADER_DEFRAMER_CORE_ASSERT_SVH
`define FRAME_HEADER_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FHD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fhd_pkg.sv */
// Package: item types, status codes and header constants of the deframer.
package fhd_pkg;

  localparam logic [2:0]  HdrBytes = 3'd5;
  localparam logic [16:0] CountMax = 17'h1FFFF;

  typedef enum logic [1:0] {
    HdrVersion = 2'd0,
    HdrType    = 2'd1,
    HdrFlag    = 2'd2,
    HdrLenHi   = 2'd3
  } hdr_field_e;

  typedef enum logic [2:0] {
    StPending      = 3'd0,
    StOk           = 3'd1,
    StTooShort     = 3'd2,
    StPayloadShort = 3'd3,
    StPayloadLong  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    status_e     status;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [7:0]  flag;
    logic [15:0] declared_length;
  } out_item_t;

endpackage

/* rtl/core/frame_header_deframer_core.sv */
// Top level: length-prefixed frame deframer with registered result.
// The result of an accepted item is registered and output in the cycle after it.
// One byte per cycle unless stalled; a new item enters while the held result drains.
// Stall on input follows only the output register (full and stalled downstream).
// Reset (async, active low) clears header, length, counter and output valid;
// after each end-of-buffer byte the parser rearms to the same cleared state.
module frame_header_deframer_core
  import fhd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t result;
  logic      in_accept;

  // Input blocks only when a held result cannot leave this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // All per-byte work: header capture, payload index, status on last byte.
  fhd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_accept),
    .item_i   (in_item_i),
    .result_o (result)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register: loads only on accept, so a stalled result holds.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/core/fhd_parser.sv */
// Header capture, payload counting and end-of-buffer status for one byte.
module fhd_parser
  import fhd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flag_q, flag_d;
  logic [15:0] len_q, len_d;
  logic [16:0] cnt_q, cnt_d;

  always_comb begin
    hdr_pos_d = hdr_pos_q;
    ver_d     = ver_q;
    type_d    = type_q;
    flag_d    = flag_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    result_o  = '0;

    if (hdr_pos_q < HdrBytes) begin
      if (hdr_pos_q[2]) begin
        // fifth header byte: low half of the length
        len_d = {len_q[15:8], item_i.rx_byte};
      end else begin
        case (hdr_pos_q[1:0])
          HdrVersion: ver_d  = item_i.rx_byte;
          HdrType:    type_d = item_i.rx_byte;
          HdrFlag:    flag_d = item_i.rx_byte;
          HdrLenHi:   len_d  = {item_i.rx_byte, len_q[7:0]};
          default:    len_d  = len_q;
        endcase
      end
      hdr_pos_d = hdr_pos_q + 3'd1;
    end else begin
      if (cnt_q < {1'b0, len_q}) begin
        result_o.payload_valid = 1'b1;
        result_o.payload_byte  = item_i.rx_byte;
        result_o.payload_index = cnt_q[15:0];
      end
      if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 17'd1;
      end
    end

    result_o.version         = ver_d;
    result_o.msg_type        = type_d;
    result_o.flag            = flag_d;
    result_o.declared_length = len_d;
    result_o.status          = StPending;

    if (item_i.end_of_buffer) begin
      result_o.frame_done = 1'b1;
      if (hdr_pos_d < HdrBytes) begin
        result_o.status = StTooShort;
      end else if (cnt_d == {1'b0, len_d}) begin
        result_o.status = StOk;
      end else if (cnt_d < {1'b0, len_d}) begin
        result_o.status = StPayloadShort;
      end else begin
        result_o.status = StPayloadLong;
      end
      // rearm for the next buffer
      hdr_pos_d = '0;
      ver_d     = '0;
      type_d    = '0;
      flag_d    = '0;
      len_d     = '0;
      cnt_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= '0;
      ver_q     <= '0;
      type_q    <= '0;
      flag_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      hdr_pos_q <= hdr_pos_d;
      ver_q     <= ver_d;
      type_q    <= type_d;
      flag_q    <= flag_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

/* rtl/core/fhd_checker.sv */
// Port-level checker for the deframer, bound to the top level.
`include "frame_header_deframer_core_assert.svh"

module fhd_checker
  import fhd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic out_take;
  logic after_done_q;
  logic hdr_clean;
  logic idx_ok;

  assign out_take = out_valid_o & ~out_stall_i;

  // first byte of a buffer: header byte, nothing but the version captured
  assign hdr_clean = !out_item_o.payload_valid && (out_item_o.msg_type == 8'd0) &&
                     (out_item_o.flag == 8'd0) && (out_item_o.declared_length == 16'd0);

  assign idx_ok = (out_item_o.payload_index < out_item_o.declared_length) &&
                  (out_item_o.status != StTooShort);

  // Set at reset and once a frame_done item left; cleared by the next taken item without frame_done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_done_q <= 1'b1;
    end else if (out_take) begin
      after_done_q <= out_item_o.frame_done;
    end
  end

  `FHD_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `FHD_ASSERT_NEXT(a_item_holds, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o), "stalled result changed")
  `FHD_ASSERT_NOW(a_rearm, clk_i, rst_ni, out_valid_o && after_done_q, hdr_clean, "first byte of a buffer not clean")
  `FHD_ASSERT_NOW(a_index_range, clk_i, rst_ni, out_valid_o && out_item_o.payload_valid, idx_ok, "payload byte beyond length")
  `FHD_ASSERT_NOW(a_in_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled with output free")

endmodule

bind frame_header_deframer_core fhd_checker u_fhd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the frame deframer: directed byte table, then random frames.
module tb_top;
  import fhd_pkg::*;

  localparam int RandItems  = 1900;
  localparam int CalmItems  = 200;     // tail of the random part with no idling
  localparam int HoldCycles = 120;     // long receiver hold-off, fills the block
  localparam int IdleLimit  = 2000;    // watchdog: cycles with no handshake at all
  localparam int MaxReports = 100;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  frame_header_deframer_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  // Predictor state: mirrors the parser, cleared at reset and after each last byte.
  logic [2:0]  hdr_seen = '0;
  logic [7:0]  ver_q    = '0;
  logic [7:0]  kind_q   = '0;
  logic [7:0]  flag_q   = '0;
  logic [15:0] len_q    = '0;
  logic [16:0] body_cnt = '0;

  out_item_t   pending_results[$];

  bit          gaps_on      = 1'b1;
  bit          hold_req     = 1'b0;
  int unsigned gap_odds     = 0;
  int unsigned stall_odds   = 2;
  int unsigned bytes_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } table_row_t;

  table_row_t rows[$];

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One accepted byte through the parser; returns its result and advances state.
  function automatic out_item_t deframe_step(input in_item_t item);
    out_item_t r;
    r        = '0;
    r.status = StPending;
    if (hdr_seen < HdrBytes) begin
      case (hdr_seen)
        HdrVersion: ver_q  = item.rx_byte;
        HdrType:    kind_q = item.rx_byte;
        HdrFlag:    flag_q = item.rx_byte;
        HdrLenHi:   len_q  = {item.rx_byte, len_q[7:0]};
        default:    len_q  = {len_q[15:8], item.rx_byte};
      endcase
      hdr_seen = hdr_seen + 3'd1;
    end else begin
      if (body_cnt < {1'b0, len_q}) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = item.rx_byte;
        r.payload_index = body_cnt[15:0];
      end
      if (body_cnt < CountMax) body_cnt = body_cnt + 17'd1;
    end
    r.version         = ver_q;
    r.msg_type        = kind_q;
    r.flag            = flag_q;
    r.declared_length = len_q;
    if (item.end_of_buffer) begin
      r.frame_done = 1'b1;
      if (hdr_seen < HdrBytes)            r.status = StTooShort;
      else if (body_cnt == {1'b0, len_q}) r.status = StOk;
      else if (body_cnt < {1'b0, len_q})  r.status = StPayloadShort;
      else                                r.status = StPayloadLong;
      // rearm for the next buffer
      hdr_seen = '0;
      ver_q    = '0;
      kind_q   = '0;
      flag_q   = '0;
      len_q    = '0;
      body_cnt = '0;
    end
    return r;
  endfunction

  function automatic out_item_t frame_result(input logic pv, input logic [7:0] pb,
      input logic [15:0] pidx, input logic done, input status_e st, input logic [7:0] ver,
      input logic [7:0] kind, input logic [7:0] flg, input logic [15:0] dlen);
    out_item_t r;
    r.payload_valid   = pv;
    r.payload_byte    = pb;
    r.payload_index   = pidx;
    r.frame_done      = done;
    r.status          = st;
    r.version         = ver;
    r.msg_type        = kind;
    r.flag            = flg;
    r.declared_length = dlen;
    return r;
  endfunction

  function automatic in_item_t loose_byte(input bit last);
    in_item_t item;
    item.rx_byte       = 8'($urandom);
    item.end_of_buffer = last;
    return item;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic eob, input bit typed = 1'b0,
                         input out_item_t want = '0);
    table_row_t row;
    row.stim.rx_byte       = b;
    row.stim.end_of_buffer = eob;
    row.typed              = typed;
    row.want               = want;
    rows = {rows, row};
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // Valid is left high on return so back-to-back items see no extra edge on it.
  task automatic push_byte(input in_item_t item, input bit typed = 1'b0,
                           input out_item_t want = '0);
    out_item_t predicted;
    if (gaps_on && gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predicted = deframe_step(item);
    if (typed) predicted = want;
    pending_results = {pending_results, predicted};
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Header with random version/type/flag, then body random bytes; last byte flagged.
  task automatic send_frame(input logic [15:0] dlen, input int body);
    logic [7:0] head [HdrBytes];
    in_item_t   item;
    head[0] = 8'($urandom);
    head[1] = 8'($urandom);
    head[2] = 8'($urandom);
    head[3] = dlen[15:8];
    head[4] = dlen[7:0];
    for (int i = 0; i < HdrBytes; i++) begin
      item.rx_byte       = head[i];
      item.end_of_buffer = (body == 0) && (i == HdrBytes - 1);
      push_byte(item);
    end
    for (int i = 0; i < body; i++) push_byte(loose_byte(i == body - 1));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Result side: every taken result is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) $error("result item with nothing pending");
        end else begin
          want = pending_results.pop_front();
          check_field("payload_valid", want.payload_valid, out_item_o.payload_valid);
          check_field("payload_byte", want.payload_byte, out_item_o.payload_byte);
          check_field("payload_index", want.payload_index, out_item_o.payload_index);
          check_field("frame_done", want.frame_done, out_item_o.frame_done);
          check_field("status", want.status, out_item_o.status);
          check_field("version", want.version, out_item_o.version);
          check_field("msg_type", want.msg_type, out_item_o.msg_type);
          check_field("flag", want.flag, out_item_o.flag);
          check_field("declared_length", want.declared_length, out_item_o.declared_length);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < IdleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when gaps are off.
  initial begin : drain_side
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) == 0) stall_odds = $urandom_range(0, 3);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (gaps_on && stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int          body;
    logic [15:0] dlen;
    bit          hold_done;
    hold_done  = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Typed expectations where the answer is obvious.
    // single-byte buffer: too short, only the version captured
    add_row(8'h00, 1'b1, 1'b1, frame_result(1'b0, 8'h00, 16'd0, 1'b1, StTooShort,
            8'h00, 8'h00, 8'h00, 16'h0000));
    // header cut after the high length byte
    add_row(8'hA5, 1'b0, 1'b1, frame_result(1'b0, 8'h00, 16'd0, 1'b0, StPending,
            8'hA5, 8'h00, 8'h00, 16'h0000));
    add_row(8'h5A, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h80, 1'b1, 1'b1, frame_result(1'b0, 8'h00, 16'd0, 1'b1, StTooShort,
            8'hA5, 8'h5A, 8'hFF, 16'h8000));
    // exact two-byte payload
    add_row(8'h10, 1'b0);
    add_row(8'h20, 1'b0);
    add_row(8'h30, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'hAA, 1'b0, 1'b1, frame_result(1'b1, 8'hAA, 16'd0, 1'b0, StPending,
            8'h10, 8'h20, 8'h30, 16'h0002));
    add_row(8'h55, 1'b1, 1'b1, frame_result(1'b1, 8'h55, 16'd1, 1'b1, StOk,
            8'h10, 8'h20, 8'h30, 16'h0002));
    // zero length with one extra byte: counted, not passed, too long
    add_row(8'h01, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h03, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h33, 1'b1, 1'b1, frame_result(1'b0, 8'h00, 16'd0, 1'b1, StPayloadLong,
            8'h01, 8'h02, 8'h03, 16'h0000));
    // all-ones header, one payload byte: short
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, frame_result(1'b1, 8'h00, 16'd0, 1'b1, StPayloadShort,
            8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    gap_odds = 4;
    foreach (rows[i]) push_byte(rows[i].stim, rows[i].typed, rows[i].want);

    // Random frames: mostly well formed, some short/long bodies, some cut headers.
    bytes_sent = 0;
    while (bytes_sent < RandItems) begin
      gap_odds = $urandom_range(0, 3);
      if (bytes_sent > RandItems - CalmItems) gaps_on = 1'b0;
      if (!hold_done && bytes_sent > RandItems / 3) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        body = $urandom_range(1, 4);
        for (int i = 0; i < body; i++) push_byte(loose_byte(i == body - 1));
      end else begin
        if (kind == 1) begin
          dlen = 16'($urandom);
          body = $urandom_range(0, 30);
        end else begin
          dlen = 16'($urandom_range(0, 24));
          case ($urandom_range(0, 3))
            0:       body = dlen + $urandom_range(1, 5);
            1:       body = $urandom_range(0, dlen);
            default: body = dlen;
          endcase
        end
        send_frame(dlen, body);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
